/* rtl/core/dpas_pkg.sv */
// Package for the data-processing ALU and shifter unit: opcode, shift and
// operand-form codes, the shifter result type and the barrel shift function.
// No dependencies.
package dpas_pkg;

  localparam int unsigned DataWidth = 32;
  localparam int unsigned AmtWidth  = 6;

  typedef enum logic [3:0] {
    OP_AND = 4'd0,
    OP_EOR = 4'd1,
    OP_SUB = 4'd2,
    OP_RSB = 4'd3,
    OP_ADD = 4'd4,
    OP_ADC = 4'd5,
    OP_SBC = 4'd6,
    OP_RSC = 4'd7,
    OP_TST = 4'd8,
    OP_TEQ = 4'd9,
    OP_CMP = 4'd10,
    OP_CMN = 4'd11,
    OP_ORR = 4'd12,
    OP_MOV = 4'd13,
    OP_BIC = 4'd14,
    OP_MVN = 4'd15
  } alu_op_e;

  typedef enum logic [1:0] {
    SH_LSL = 2'd0,
    SH_LSR = 2'd1,
    SH_ASR = 2'd2,
    SH_ROR = 2'd3
  } shift_type_e;

  typedef enum logic [1:0] {
    FORM_IMM_SHIFT = 2'd0,
    FORM_REG_SHIFT = 2'd1,
    FORM_ROT_IMM   = 2'd2,
    FORM_RESERVED  = 2'd3
  } operand_form_e;

  typedef struct packed {
    logic [DataWidth-1:0] value;
    logic                 carry;
  } shift_res_t;

  // amount runs 0 to 33; zero passes value and carry
  function automatic shift_res_t barrel_shift(
    input logic [DataWidth-1:0] v,
    input shift_type_e          kind,
    input logic [AmtWidth-1:0]  amt,
    input logic                 cin
  );
    logic [DataWidth:0]     wide;
    logic [2*DataWidth-1:0] dbl;
    logic [AmtWidth-1:0]    amt_asr;
    shift_res_t             res;
    wide    = '0;
    dbl     = '0;
    amt_asr = (amt > AmtWidth'(32)) ? AmtWidth'(32) : amt;
    res     = '{value: v, carry: cin};
    if (amt != '0) begin
      unique case (kind)
        SH_LSL: begin
          wide = {1'b0, v} << amt;
          res  = '{value: wide[DataWidth-1:0], carry: wide[DataWidth]};
        end
        SH_LSR: begin
          wide = {v, 1'b0} >> amt;
          res  = '{value: wide[DataWidth:1], carry: wide[0]};
        end
        SH_ASR: begin
          wide = $unsigned($signed({v, 1'b0}) >>> amt_asr);
          res  = '{value: wide[DataWidth:1], carry: wide[0]};
        end
        default: begin
          dbl = {v, v} >> amt[4:0];
          res = '{value: dbl[DataWidth-1:0], carry: dbl[DataWidth-1]};
        end
      endcase
    end
    return res;
  endfunction

endpackage

/* rtl/core/data_processing_alu_shifter_unit.sv */
// Top level of the data-processing ALU with barrel shifter.
// Uses dpas_pkg for codes, the shifter result type and the shift function.
//
// One instruction is transferred at each clock edge where start_i is high;
// busy_o stays low, so an instruction may be issued every cycle. The result
// appears with done_o after the input register, then the shifter and 32-bit
// adder in a single combinational pass into the result register, and is held
// for exactly one cycle, since the receiver cannot stall.
module data_processing_alu_shifter_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [3:0]  func_i,
  input  logic        save_flags_i,
  input  logic [1:0]  operand_form_i,
  input  logic [1:0]  shift_type_i,
  input  logic [7:0]  shift_amount_i,
  input  logic [31:0] first_operand_i,
  input  logic [31:0] second_operand_i,
  input  logic [3:0]  flags_in_i,
  output logic        done_o,
  output logic [31:0] result_o,
  output logic        writes_result_o,
  output logic [3:0]  flags_out_o
);

  logic                  in_valid_q;
  dpas_pkg::alu_op_e     func_q;
  logic                  save_q;
  dpas_pkg::operand_form_e form_q;
  dpas_pkg::shift_type_e type_q;
  logic [7:0]            amt_q;
  logic [31:0]           rn_q;
  logic [31:0]           op2_q;
  logic [3:0]            fin_q;

  logic                  done_q;
  logic [31:0]           result_q, result_d;
  logic                  writes_q, writes_d;
  logic [3:0]            flags_q, flags_d;

  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      in_valid_q <= start_i && !busy_o;
      done_q     <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      func_q <= dpas_pkg::alu_op_e'(func_i);
      save_q <= save_flags_i;
      form_q <= dpas_pkg::operand_form_e'(operand_form_i);
      type_q <= dpas_pkg::shift_type_e'(shift_type_i);
      amt_q  <= shift_amount_i;
      rn_q   <= first_operand_i;
      op2_q  <= second_operand_i;
      fin_q  <= flags_in_i;
    end
    if (in_valid_q) begin
      result_q <= result_d;
      writes_q <= writes_d;
      flags_q  <= flags_d;
    end
  end

  // operand two shifter
  logic                 cin;
  logic [4:0]           amt5;
  logic [5:0]           sh_amt;
  dpas_pkg::shift_res_t sh;
  logic [31:0]          rm;
  logic                 sc;
  logic [63:0]          rot_dbl;
  logic [4:0]           rot_amt;

  assign cin     = fin_q[1];
  assign amt5    = amt_q[4:0];
  assign rot_amt = {amt_q[3:0], 1'b0};
  assign rot_dbl = {24'd0, op2_q[7:0], 24'd0, op2_q[7:0]} >> rot_amt;

  always_comb begin
    sh_amt = 6'd0;
    unique case (type_q)
      dpas_pkg::SH_LSL: begin
        sh_amt = (form_q == dpas_pkg::FORM_IMM_SHIFT) ? {1'b0, amt5}
               : (amt_q > 8'd33) ? 6'd33 : amt_q[5:0];
      end
      dpas_pkg::SH_LSR: begin
        sh_amt = (form_q == dpas_pkg::FORM_IMM_SHIFT)
               ? ((amt5 != '0) ? {1'b0, amt5} : 6'd32)
               : (amt_q > 8'd33) ? 6'd33 : amt_q[5:0];
      end
      dpas_pkg::SH_ASR: begin
        sh_amt = (form_q == dpas_pkg::FORM_IMM_SHIFT)
               ? ((amt5 != '0) ? {1'b0, amt5} : 6'd32)
               : (amt_q > 8'd32) ? 6'd32 : amt_q[5:0];
      end
      default: begin
        if (form_q == dpas_pkg::FORM_IMM_SHIFT) begin
          sh_amt = {1'b0, amt5};
        end else begin
          sh_amt = (amt_q == '0) ? 6'd0 : ((amt5 != '0) ? {1'b0, amt5} : 6'd32);
        end
      end
    endcase
  end

  assign sh = dpas_pkg::barrel_shift(op2_q, type_q, sh_amt, cin);

  always_comb begin
    rm = sh.value;
    sc = sh.carry;
    if (form_q == dpas_pkg::FORM_IMM_SHIFT && type_q == dpas_pkg::SH_ROR && amt5 == '0) begin
      rm = {cin, op2_q[31:1]};
      sc = op2_q[0];
    end else if (form_q == dpas_pkg::FORM_ROT_IMM || form_q == dpas_pkg::FORM_RESERVED) begin
      rm = rot_dbl[31:0];
      sc = (amt_q[3:0] != '0) ? rot_dbl[31] : cin;
    end
  end

  // alu
  logic [31:0] add_a, add_b, logic_res;
  logic        add_cy, arith;
  logic [32:0] sum;
  logic        setf;
  logic [31:0] res;

  always_comb begin
    add_a     = rn_q;
    add_b     = rm;
    add_cy    = 1'b0;
    arith     = 1'b1;
    logic_res = rm;
    unique case (func_q) inside
      dpas_pkg::OP_AND, dpas_pkg::OP_TST: begin
        arith = 1'b0; logic_res = rn_q & rm;
      end
      dpas_pkg::OP_EOR, dpas_pkg::OP_TEQ: begin
        arith = 1'b0; logic_res = rn_q ^ rm;
      end
      dpas_pkg::OP_SUB, dpas_pkg::OP_CMP: begin
        add_b = ~rm; add_cy = 1'b1;
      end
      dpas_pkg::OP_RSB: begin
        add_a = rm; add_b = ~rn_q; add_cy = 1'b1;
      end
      dpas_pkg::OP_ADD, dpas_pkg::OP_CMN: begin
        add_cy = 1'b0;
      end
      dpas_pkg::OP_ADC: begin
        add_cy = cin;
      end
      dpas_pkg::OP_SBC: begin
        add_b = ~rm; add_cy = cin;
      end
      dpas_pkg::OP_RSC: begin
        add_a = rm; add_b = ~rn_q; add_cy = cin;
      end
      dpas_pkg::OP_ORR: begin
        arith = 1'b0; logic_res = rn_q | rm;
      end
      dpas_pkg::OP_MOV: begin
        arith = 1'b0; logic_res = rm;
      end
      dpas_pkg::OP_BIC: begin
        arith = 1'b0; logic_res = rn_q & ~rm;
      end
      default: begin
        arith = 1'b0; logic_res = ~rm;
      end
    endcase
  end

  assign sum      = {1'b0, add_a} + {1'b0, add_b} + {32'd0, add_cy};
  assign res      = arith ? sum[31:0] : logic_res;
  assign writes_d = !(func_q == dpas_pkg::OP_TST || func_q == dpas_pkg::OP_TEQ ||
                      func_q == dpas_pkg::OP_CMP || func_q == dpas_pkg::OP_CMN);
  assign setf     = save_q || !writes_d;
  assign result_d = res;

  always_comb begin
    flags_d = fin_q;
    if (setf) begin
      flags_d[3] = res[31];
      flags_d[2] = (res == '0);
      if (arith) begin
        flags_d[1] = sum[32];
        flags_d[0] = (~(add_a[31] ^ add_b[31])) & (add_a[31] ^ res[31]);
      end else begin
        flags_d[1] = sc;
      end
    end
  end

  assign done_o          = done_q;
  assign result_o        = result_q;
  assign writes_result_o = writes_q;
  assign flags_out_o     = flags_q;

  a_done_follows_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i, 2))
    else $error("result strobe without a transfer two cycles earlier");

  a_compare_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (writes_result_o == !($past(func_i, 2) == dpas_pkg::OP_TST ||
                                     $past(func_i, 2) == dpas_pkg::OP_TEQ ||
                                     $past(func_i, 2) == dpas_pkg::OP_CMP ||
                                     $past(func_i, 2) == dpas_pkg::OP_CMN)))
    else $error("write enable does not match opcode");

  a_flags_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && writes_result_o && !$past(save_flags_i, 2) |->
      flags_out_o == $past(flags_in_i, 2))
    else $error("flags changed without save bit");

endmodule
